// ===== design/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_RDWT,
    ST_EVRD,
    ST_MOVE,
    ST_DONE
  } state_t;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage
`default_nettype wire

// ===== design/lkvc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lkvc_req_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value_in;
  modport source (output valid, opcode, key, value_in, input ready);
  modport sink   (input valid, opcode, key, value_in, output ready);
endinterface

interface lkvc_rsp_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] value_out;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;
  modport source (output valid, hit, value_out, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, value_out, evicted, evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/lkvc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  payload
// in_*      sink       opcode, key, value_in
// out_*     source     hit, value_out, evicted, evicted_key
// cfg_*     sink       capacity_in_use (5 bits)
//
// steps: from accept to result valid, the scan walks the recency list one
//   position at a time through one key compare (SCAN, then CHECK); a hit or
//   eviction waits in RDWT and EVRD on the registered RAM read, then the order
//   list shifts one position a cycle in MOVE.
// reset: rst_n synchronous active low; clears count and out valid, sets the order list to identity and capacity to 16.
// stalls: in_ready is low while an item is at work or its result waits; the
//   next item can be accepted only once the last result has been taken.
module lru_key_value_cache #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  lkvc_req_if.sink in_ch,
  lkvc_rsp_if.source out_ch,
  lkvc_cfg_if.sink cfg_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lkvc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]         order_r [DEPTH];
  logic [CW-1:0]         count_r;
  logic [4:0]            cap_r;
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CW-1:0]         pos_r;   // scan position
  logic [CW-1:0]         mv_r;    // move position
  logic [AW-1:0]         slot_r;
  logic                  hit_r, ev_r;
  logic [VALUE_BITS-1:0] vout_r;
  logic [KEY_BITS-1:0]   evk_r;
  logic                  ovalid_r;

  logic [CW-1:0]         cap_eff;
  logic                  k_we, v_we;
  logic [AW-1:0]         k_ra, v_ra, w_addr;
  logic [KEY_BITS-1:0]   k_rd;
  logic [VALUE_BITS-1:0] v_rd;
  logic [CW-1:0]         pos_prev;

  assign in_ch.ready  = (state_r == lkvc_pkg::ST_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.hit = hit_r;
  assign out_ch.value_out = vout_r;
  assign out_ch.evicted = ev_r;
  assign out_ch.evicted_key = evk_r;

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  assign pos_prev = pos_r - CW'(1);
  // key reads follow the scan position in SCAN, else slot_r; value reads use slot_r
  assign k_ra   = (state_r == lkvc_pkg::ST_SCAN) ? order_r[pos_r[AW-1:0]] : slot_r;
  assign v_ra   = slot_r;
  assign w_addr = slot_r;
  assign k_we   = (state_r == lkvc_pkg::ST_MOVE) && (mv_r == '0) &&
                  (op_r == lkvc_pkg::OP_INSERT) && !hit_r;
  assign v_we   = (state_r == lkvc_pkg::ST_MOVE) && (mv_r == '0) &&
                  (op_r == lkvc_pkg::OP_INSERT);

  lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_keys (
    .clk(clk), .we(k_we), .waddr(w_addr), .wdata(key_r), .raddr(k_ra), .rdata(k_rd)
  );
  lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_vals (
    .clk(clk), .we(v_we), .waddr(w_addr), .wdata(val_r), .raddr(v_ra), .rdata(v_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_nxt = lkvc_pkg::ST_SCAN;
      end
      lkvc_pkg::ST_SCAN: begin
        if (pos_r >= count_r) begin
          if (op_r == lkvc_pkg::OP_LOOKUP) state_nxt = lkvc_pkg::ST_DONE;
          else if (count_r >= cap_eff) state_nxt = lkvc_pkg::ST_RDWT;
          else state_nxt = lkvc_pkg::ST_MOVE;
        end else begin
          state_nxt = lkvc_pkg::ST_CHECK;
        end
      end
      lkvc_pkg::ST_CHECK: begin
        if (k_rd == key_r) state_nxt = lkvc_pkg::ST_RDWT;
        else state_nxt = lkvc_pkg::ST_SCAN;
      end
      // target slot read is in flight
      lkvc_pkg::ST_RDWT:  state_nxt = lkvc_pkg::ST_EVRD;
      lkvc_pkg::ST_EVRD:  state_nxt = lkvc_pkg::ST_MOVE;
      lkvc_pkg::ST_MOVE: begin
        if (mv_r == '0) state_nxt = lkvc_pkg::ST_DONE;
      end
      lkvc_pkg::ST_DONE:  state_nxt = lkvc_pkg::ST_IDLE;
      default:            state_nxt = lkvc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lkvc_pkg::ST_IDLE;
      count_r  <= '0;
      cap_r    <= 5'd16;
      ovalid_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) order_r[i] <= AW'(i);
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) cap_r <= cfg_ch.data;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        lkvc_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op_r   <= in_ch.opcode;
            key_r  <= in_ch.key;
            val_r  <= in_ch.value_in;
            pos_r  <= '0;
            hit_r  <= 1'b0;
            ev_r   <= 1'b0;
            vout_r <= '0;
            evk_r  <= '0;
          end
        end
        lkvc_pkg::ST_SCAN: begin
          pos_r <= pos_r + CW'(1);
          if (pos_r >= count_r && op_r == lkvc_pkg::OP_INSERT) begin
            if (count_r >= cap_eff) begin
              mv_r   <= count_r - CW'(1);
              slot_r <= order_r[AW'(count_r - CW'(1))];
              ev_r   <= 1'b1;
            end else begin
              mv_r    <= count_r;
              slot_r  <= order_r[count_r[AW-1:0]];
              count_r <= count_r + CW'(1);
            end
          end
        end
        lkvc_pkg::ST_CHECK: begin
          if (k_rd == key_r) begin
            hit_r  <= 1'b1;
            mv_r   <= pos_prev;
            slot_r <= order_r[pos_prev[AW-1:0]];
          end
        end
        lkvc_pkg::ST_EVRD: begin
          if (ev_r) evk_r <= k_rd;
          if (op_r == lkvc_pkg::OP_LOOKUP) vout_r <= v_rd;
        end
        lkvc_pkg::ST_MOVE: begin
          // one position of the recency shift a cycle
          if (mv_r == '0) begin
            order_r[0] <= slot_r;
          end else begin
            order_r[mv_r[AW-1:0]] <= order_r[AW'(mv_r - CW'(1))];
            mv_r <= mv_r - CW'(1);
          end
        end
        lkvc_pkg::ST_DONE: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps
module tb_lru_key_value_cache;

  localparam int DEPTH = 16;
  localparam int WDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    logic        evicted;
    logic [63:0] evicted_key;
  } lookup_result_t;

  typedef struct {
    logic        op;
    logic [63:0] key;
    logic [31:0] val;
    logic        typed;
    logic        x_hit;
    logic [31:0] x_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  lkvc_req_if #(.KEY_BITS(64), .VALUE_BITS(32)) req_if ();
  lkvc_rsp_if #(.KEY_BITS(64), .VALUE_BITS(32)) rsp_if ();
  lkvc_cfg_if cfg_if ();

  lru_key_value_cache #(.DEPTH(DEPTH), .KEY_BITS(64), .VALUE_BITS(32)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_if.sink), .out_ch(rsp_if.source),
    .cfg_ch(cfg_if.sink)
  );

  // cache mirror
  logic [63:0] mir_keys [DEPTH];
  logic [31:0] mir_vals [DEPTH];
  int          mir_order [DEPTH];
  int          mir_count;
  logic [4:0]  mir_capacity;

  lookup_result_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;
  bit stim_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void cache_reset();
    for (int i = 0; i < DEPTH; i++) mir_order[i] = i;
    mir_count = 0;
    mir_capacity = 5'd16;
  endfunction

  // move order position to front
  function automatic void promote(int pos);
    int slot;
    slot = mir_order[pos];
    for (int i = pos; i > 0; i--) mir_order[i] = mir_order[i-1];
    mir_order[0] = slot;
  endfunction

  function automatic lookup_result_t cache_access(logic op, logic [63:0] key,
                                                  logic [31:0] val);
    lookup_result_t r;
    int pos, cap, p, s;
    r = '0;
    pos = -1;
    for (int i = 0; i < mir_count; i++)
      if (pos < 0 && mir_keys[mir_order[i]] == key) pos = i;
    if (pos >= 0) begin
      r.hit = 1'b1;
      if (op == lkvc_pkg::OP_LOOKUP) r.value_out = mir_vals[mir_order[pos]];
      else mir_vals[mir_order[pos]] = val;
      promote(pos);
    end else if (op == lkvc_pkg::OP_INSERT) begin
      cap = (mir_capacity == 0) ? 1 : (mir_capacity > DEPTH) ? DEPTH : mir_capacity;
      if (mir_count >= cap) begin
        p = mir_count - 1;
        r.evicted = 1'b1;
        r.evicted_key = mir_keys[mir_order[p]];
      end else begin
        p = mir_count;
        mir_count++;
      end
      s = mir_order[p];
      mir_keys[s] = key;
      mir_vals[s] = val;
      promote(p);
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample and check result transactions
  always @(posedge clk) begin
    lookup_result_t got, want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.hit, rsp_if.value_out, rsp_if.evicted, rsp_if.evicted_key};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {63'd0, got.hit}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit)
          report_mismatch("hit", 64'(got.hit), 64'(want.hit));
        if (got.value_out !== want.value_out)
          report_mismatch("value_out", 64'(got.value_out), 64'(want.value_out));
        if (got.evicted !== want.evicted)
          report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
        if (got.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
      end
    end
  end

  // receiver ready with random stalls
  initial begin
    int g;
    rsp_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold) begin
        rsp_if.ready <= 1'b0;
        @(posedge clk);
      end else begin
        g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
        if (g > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n || (stim_done && pending_results.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [63:0] key,
                           input logic [31:0] val, output lookup_result_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.key <= key;
    req_if.value_in <= val;
    @(posedge clk iff req_if.ready);
    r = cache_access(op, key, val);
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= cap;
    @(posedge clk iff cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mir_capacity = cap;
    @(posedge clk);
  endtask

  // random key from a small pool, with an occasional wide key
  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 32'($urandom_range(0, 23))};
  endfunction

  task automatic run_random(input int count, input int hold_at);
    lookup_result_t r;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (300) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      send_item($urandom_range(0, 1) ? lkvc_pkg::OP_INSERT : lkvc_pkg::OP_LOOKUP,
                pick_key(), $urandom, r);
    end
  endtask

  stim_row_t dir_rows [$];

  function automatic stim_row_t row(logic op, logic [63:0] k, logic [31:0] v,
                                    logic typed = 1'b0, logic xh = 1'b0,
                                    logic [31:0] xv = 32'd0);
    stim_row_t s;
    s = '{op, k, v, typed, xh, xv};
    return s;
  endfunction

  initial begin
    lookup_result_t r;
    req_if.valid = 1'b0;
    req_if.opcode = lkvc_pkg::OP_LOOKUP;
    req_if.key = '0;
    req_if.value_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    cache_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: misses after reset, extremes, updates
    dir_rows = '{
      row(lkvc_pkg::OP_LOOKUP, 64'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0),
      row(lkvc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, 1'b0, 32'd0),
      row(lkvc_pkg::OP_INSERT, 64'd0, 32'hFFFF_FFFF),
      row(lkvc_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0),
      row(lkvc_pkg::OP_LOOKUP, 64'd0, 32'd0, 1'b1, 1'b1, 32'hFFFF_FFFF),
      row(lkvc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 1'b1, 1'b1, 32'd0),
      row(lkvc_pkg::OP_INSERT, 64'd0, 32'h1234_5678),
      row(lkvc_pkg::OP_LOOKUP, 64'd0, 32'd0, 1'b1, 1'b1, 32'h1234_5678),
      row(lkvc_pkg::OP_INSERT, 64'hAAAA_5555_AAAA_5555, 32'hA5A5_5A5A),
      row(lkvc_pkg::OP_INSERT, 64'h5555_AAAA_5555_AAAA, 32'h5A5A_A5A5),
      row(lkvc_pkg::OP_LOOKUP, 64'd7, 32'd0, 1'b1, 1'b0, 32'd0)
    };
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val, r);
      if (dir_rows[i].typed && (r.hit !== dir_rows[i].x_hit ||
                                r.value_out !== dir_rows[i].x_val))
        report_mismatch("directed row", 64'(i), 64'd0);
    end

    // capacity 2: eviction and capacity shrink below count
    write_capacity(5'd2);
    for (int k = 0; k < 5; k++) send_item(lkvc_pkg::OP_INSERT, 64'(100 + k), 32'(k), r);
    send_item(lkvc_pkg::OP_LOOKUP, 64'd103, 32'd0, r);
    send_item(lkvc_pkg::OP_INSERT, 64'd200, 32'd9, r);
    // zero acts as one, max field value acts as full depth
    write_capacity(5'd0);
    send_item(lkvc_pkg::OP_INSERT, 64'd300, 32'd1, r);
    send_item(lkvc_pkg::OP_INSERT, 64'd301, 32'd2, r);
    write_capacity(5'd31);
    send_item(lkvc_pkg::OP_INSERT, 64'd302, 32'd3, r);

    // random phases over several capacities
    write_capacity(5'd16);
    run_random(600, 100);
    // sender pause until every result is back
    wait_drained();
    write_capacity(5'd1);
    run_random(300, -1);
    write_capacity(5'd5);
    run_random(400, 50);
    write_capacity(5'd31);
    run_random(300, -1);
    write_capacity(5'd12);
    run_random(330, -1);

    req_if.valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
